// ===== design/mbwk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum body/wheel kinematics package
// Shared widths, item types, register indexes and fixed-point helpers.
// ----------------------------------------------------------------------------
package mbwk_pkg;

    localparam int FIELD_W        = 16;
    localparam int GAIN_W         = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int CFG_IDX_W      = 8;
    localparam int SUM_W          = FIELD_W + 2;
    localparam int PROD_W         = SUM_W + GAIN_W + 1;
    localparam int SCALED_W       = PROD_W - GAIN_FRAC_BITS;
    localparam int SAT_IN_W       = SCALED_W + 1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1 << GAIN_FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FWD_LIN_GAIN = CFG_IDX_W'(0),
        REG_FWD_ROT_GAIN = CFG_IDX_W'(1),
        REG_INV_LIN_GAIN = CFG_IDX_W'(2),
        REG_INV_ROT_GAIN = CFG_IDX_W'(3)
    } t_reg_idx;

    typedef struct packed {
        logic signed [FIELD_W-1:0] wheel_fl_speed;
        logic signed [FIELD_W-1:0] wheel_fr_speed;
        logic signed [FIELD_W-1:0] wheel_bl_speed;
        logic signed [FIELD_W-1:0] wheel_br_speed;
        logic signed [FIELD_W-1:0] cmd_vx;
        logic signed [FIELD_W-1:0] cmd_vy;
        logic signed [FIELD_W-1:0] cmd_omega;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] body_vx;
        logic signed [FIELD_W-1:0] body_vy;
        logic signed [FIELD_W-1:0] body_omega;
        logic signed [FIELD_W-1:0] setpoint_fl;
        logic signed [FIELD_W-1:0] setpoint_fr;
        logic signed [FIELD_W-1:0] setpoint_bl;
        logic signed [FIELD_W-1:0] setpoint_br;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [GAIN_W-1:0]    data;
    } t_cfg_item;

    // Multiplies by an unsigned gain and divides by 2^GAIN_FRAC_BITS,
    // rounding toward zero.
    function automatic logic signed [SCALED_W-1:0] scale_q(
        input logic signed [SUM_W-1:0] x,
        input logic [GAIN_W-1:0]       g
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] biased;
        prod   = PROD_W'(x) * PROD_W'($signed({1'b0, g}));
        biased = prod[PROD_W-1] ? prod + PROD_W'((1 << GAIN_FRAC_BITS) - 1) : prod;
        return biased[PROD_W-1:GAIN_FRAC_BITS];
    endfunction

    function automatic logic signed [FIELD_W-1:0] sat16(
        input logic signed [SAT_IN_W-1:0] x
    );
        localparam logic signed [SAT_IN_W-1:0] MAX_V = SAT_IN_W'((1 << (FIELD_W - 1)) - 1);
        localparam logic signed [SAT_IN_W-1:0] MIN_V = -SAT_IN_W'(1 << (FIELD_W - 1));
        logic signed [FIELD_W-1:0] r;
        if (x > MAX_V) begin
            r = MAX_V[FIELD_W-1:0];
        end else if (x < MIN_V) begin
            r = MIN_V[FIELD_W-1:0];
        end else begin
            r = x[FIELD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/mbwk_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum body/wheel kinematics channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface mbwk_in_if import mbwk_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mbwk_out_if import mbwk_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mbwk_cfg_if import mbwk_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/mecanum_body_wheel_kinematics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum body/wheel kinematics
// Forward and inverse mecanum kinematics on one item per clock while results are taken.
// ----------------------------------------------------------------------------
// Each item is registered on entry and its result is registered on exit; one item
// is accepted every cycle while the result side keeps taking items. The path
// between the two registers holds six 18 by 17 bit signed multiplies shared by
// the seven outputs, followed by a rounding add, a sum and a saturating compare.
// Gain writes apply to any item in the entry register when its result is
// registered. Gain writes are to be made while the block is idle; the block
// itself does not enforce this.
module mecanum_body_wheel_kinematics import mbwk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mbwk_in_if.sink    i_in,
    mbwk_out_if.source o_out,
    mbwk_cfg_if.sink   i_cfg
);

    logic [GAIN_W-1:0] r_fwd_lin_gain;
    logic [GAIN_W-1:0] r_fwd_rot_gain;
    logic [GAIN_W-1:0] r_inv_lin_gain;
    logic [GAIN_W-1:0] r_inv_rot_gain;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic out_free;
    logic s1_free;

    logic signed [SUM_W-1:0]    fl, fr, bl, br, vx, vy, om;
    logic signed [SCALED_W-1:0] sc_vx, sc_vy, sc_om, sc_diff, sc_sum, sc_rot;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_lin_gain <= GAIN_RESET;
            r_fwd_rot_gain <= GAIN_RESET;
            r_inv_lin_gain <= GAIN_RESET;
            r_inv_rot_gain <= GAIN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_FWD_LIN_GAIN: r_fwd_lin_gain <= i_cfg.data.data;
                REG_FWD_ROT_GAIN: r_fwd_rot_gain <= i_cfg.data.data;
                REG_INV_LIN_GAIN: r_inv_lin_gain <= i_cfg.data.data;
                REG_INV_ROT_GAIN: r_inv_rot_gain <= i_cfg.data.data;
                default: ;
            endcase
        end
    end

    assign out_free    = !r_out_valid || o_out.ready;
    assign s1_free     = !r_s1_valid || out_free;
    assign i_in.ready  = s1_free;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in.valid) begin
            r_s1_item <= i_in.data;
        end
        if (out_free && r_s1_valid) begin
            r_out_item <= n_out_item;
        end
    end

    always_comb begin
        fl = SUM_W'(r_s1_item.wheel_fl_speed);
        fr = SUM_W'(r_s1_item.wheel_fr_speed);
        bl = SUM_W'(r_s1_item.wheel_bl_speed);
        br = SUM_W'(r_s1_item.wheel_br_speed);
        vx = SUM_W'(r_s1_item.cmd_vx);
        vy = SUM_W'(r_s1_item.cmd_vy);
        om = SUM_W'(r_s1_item.cmd_omega);

        sc_vx   = scale_q(fl + fr + bl + br, r_fwd_lin_gain);
        sc_vy   = scale_q(-fl + fr + bl - br, r_fwd_lin_gain);
        sc_om   = scale_q(-fl + fr - bl + br, r_fwd_rot_gain);
        sc_diff = scale_q(vx - vy, r_inv_lin_gain);
        sc_sum  = scale_q(vx + vy, r_inv_lin_gain);
        sc_rot  = scale_q(om, r_inv_rot_gain);

        n_out_item.body_vx     = sat16(SAT_IN_W'(sc_vx));
        n_out_item.body_vy     = sat16(SAT_IN_W'(sc_vy));
        n_out_item.body_omega  = sat16(SAT_IN_W'(sc_om));
        n_out_item.setpoint_fl = sat16(SAT_IN_W'(sc_diff) - SAT_IN_W'(sc_rot));
        n_out_item.setpoint_fr = sat16(SAT_IN_W'(sc_sum) + SAT_IN_W'(sc_rot));
        n_out_item.setpoint_bl = sat16(SAT_IN_W'(sc_sum) - SAT_IN_W'(sc_rot));
        n_out_item.setpoint_br = sat16(SAT_IN_W'(sc_diff) + SAT_IN_W'(sc_rot));
    end

endmodule

// ===== tb/mecanum_body_wheel_kinematics_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum body/wheel kinematics testbench
// Drives wheel speed and body command items through the block and compares
// every result item with a fixed-point kinematics predictor. Gains are
// reprogrammed between phases: extremes first, then random settings. Both
// handshake sides idle at random, and one phase holds the result side off for
// a long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module mecanum_body_wheel_kinematics_test;
    import mbwk_pkg::*;

    localparam int     LATENCY_CYCLES   = 6;
    localparam int     RANDOM_PHASES    = 6;
    localparam int     ITEMS_PER_PHASE  = 172;
    localparam int     HOLD_PHASE       = 2;
    localparam int     LONG_HOLD_CYCLES = 300;
    localparam int     FIRST_UNUSED_IDX = 4;
    localparam int     IDX_TOP          = (1 << CFG_IDX_W) - 1;
    localparam int     GAIN_TOP         = (1 << GAIN_W) - 1;
    localparam longint FIELD_MAX        = (longint'(1) << (FIELD_W - 1)) - 1;
    localparam longint FIELD_MIN        = -(longint'(1) << (FIELD_W - 1));
    localparam longint TIMEOUT_NS       = 10_000_000;

    typedef logic signed [FIELD_W-1:0] t_field;

    class kinematics_scoreboard;
        logic [GAIN_W-1:0] fwd_lin;
        logic [GAIN_W-1:0] fwd_rot;
        logic [GAIN_W-1:0] inv_lin;
        logic [GAIN_W-1:0] inv_rot;
        t_out_item         expected_q[$];
        int                errors;
        int                items_noted;
        int                results_checked;

        function new();
            fwd_lin = GAIN_RESET;
            fwd_rot = GAIN_RESET;
            inv_lin = GAIN_RESET;
            inv_rot = GAIN_RESET;
        endfunction

        function void write_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
            case (idx)
                REG_FWD_LIN_GAIN: fwd_lin = value;
                REG_FWD_ROT_GAIN: fwd_rot = value;
                REG_INV_LIN_GAIN: inv_lin = value;
                REG_INV_ROT_GAIN: inv_rot = value;
                default: ;
            endcase
        endfunction

        function longint scale_by_gain(longint x, logic [GAIN_W-1:0] g);
            return (x * longint'(g)) / (longint'(1) << GAIN_FRAC_BITS);
        endfunction

        function t_field saturate(longint x);
            if (x > FIELD_MAX) begin
                x = FIELD_MAX;
            end else if (x < FIELD_MIN) begin
                x = FIELD_MIN;
            end
            return t_field'(x);
        endfunction

        function void note_input(t_in_item it);
            longint    fl, fr, bl, br, vx, vy, om, diff, sum, rot;
            t_out_item e;
            fl = longint'($signed(it.wheel_fl_speed));
            fr = longint'($signed(it.wheel_fr_speed));
            bl = longint'($signed(it.wheel_bl_speed));
            br = longint'($signed(it.wheel_br_speed));
            vx = longint'($signed(it.cmd_vx));
            vy = longint'($signed(it.cmd_vy));
            om = longint'($signed(it.cmd_omega));
            e.body_vx    = saturate(scale_by_gain(fl + fr + bl + br, fwd_lin));
            e.body_vy    = saturate(scale_by_gain(-fl + fr + bl - br, fwd_lin));
            e.body_omega = saturate(scale_by_gain(-fl + fr - bl + br, fwd_rot));
            diff = scale_by_gain(vx - vy, inv_lin);
            sum  = scale_by_gain(vx + vy, inv_lin);
            rot  = scale_by_gain(om, inv_rot);
            e.setpoint_fl = saturate(diff - rot);
            e.setpoint_fr = saturate(sum + rot);
            e.setpoint_bl = saturate(sum - rot);
            e.setpoint_br = saturate(diff + rot);
            expected_q.push_back(e);
            items_noted++;
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 10) begin
                $display("[%0t] mismatch: %s", $time, what);
            end
        endfunction

        function void compare_field(string field, t_field want, t_field got);
            if (want !== got) begin
                report($sformatf("%s expected %0d, actual %0d", field, want, got));
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results_checked++;
            if (expected_q.size() == 0) begin
                report($sformatf("result item with nothing expected: %h", got));
                return;
            end
            want = expected_q.pop_front();
            compare_field("body_vx", want.body_vx, got.body_vx);
            compare_field("body_vy", want.body_vy, got.body_vy);
            compare_field("body_omega", want.body_omega, got.body_omega);
            compare_field("setpoint_fl", want.setpoint_fl, got.setpoint_fl);
            compare_field("setpoint_fr", want.setpoint_fr, got.setpoint_fr);
            compare_field("setpoint_bl", want.setpoint_bl, got.setpoint_bl);
            compare_field("setpoint_br", want.setpoint_br, got.setpoint_br);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mbwk_in_if  in_ch();
    mbwk_out_if out_ch();
    mbwk_cfg_if cfg_ch();

    mecanum_body_wheel_kinematics dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    kinematics_scoreboard sb = new();
    bit quiet      = 1'b0;
    bit long_hold  = 1'b0;
    int gain_writes = 0;
    int input_stalls = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.note_input(in_ch.data);
            end
            if (in_ch.valid && !in_ch.ready) begin
                input_stalls++;
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.data);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.write_gain(cfg_ch.data.index, cfg_ch.data.data);
                gain_writes++;
            end
        end
    end

    // Result side: random stall bursts, one long hold-off on request.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("mecanum_body_wheel_kinematics test failed");
        $finish;
    end

    function automatic t_in_item make_item(t_field fl, t_field fr, t_field bl, t_field br,
                                           t_field vx, t_field vy, t_field om);
        t_in_item it;
        it.wheel_fl_speed = fl;
        it.wheel_fr_speed = fr;
        it.wheel_bl_speed = bl;
        it.wheel_br_speed = br;
        it.cmd_vx         = vx;
        it.cmd_vy         = vy;
        it.cmd_omega      = om;
        return it;
    endfunction

    function automatic t_field random_field();
        case ($urandom_range(0, 9))
            0: return t_field'(FIELD_MIN);
            1: return t_field'(FIELD_MAX);
            2, 3: return t_field'(int'($urandom_range(0, 511)) - 256);
            default: return t_field'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_item();
        return make_item(random_field(), random_field(), random_field(), random_field(),
                         random_field(), random_field(), random_field());
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return GAIN_RESET;
            3: return GAIN_W'(1);
            default: return GAIN_W'($urandom_range(0, GAIN_TOP));
        endcase
    endfunction

    task automatic send_item(input t_in_item it, input bit allow_gap);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (allow_gap && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four gains, then one index that the block must ignore.
    task automatic set_all_gains(input logic [GAIN_W-1:0] fl_gain, input logic [GAIN_W-1:0] fr_gain,
                                 input logic [GAIN_W-1:0] il_gain, input logic [GAIN_W-1:0] ir_gain,
                                 input logic [CFG_IDX_W-1:0] junk_idx,
                                 input logic [GAIN_W-1:0] junk_data);
        t_cfg_item seq[5];
        seq[0] = '{index: REG_FWD_LIN_GAIN, data: fl_gain};
        seq[1] = '{index: REG_FWD_ROT_GAIN, data: fr_gain};
        seq[2] = '{index: REG_INV_LIN_GAIN, data: il_gain};
        seq[3] = '{index: REG_INV_ROT_GAIN, data: ir_gain};
        seq[4] = '{index: junk_idx, data: junk_data};
        foreach (seq[k]) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= seq[k];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        t_field hi, lo;
        int     phase;
        int     k;
        hi = t_field'(FIELD_MAX);
        lo = t_field'(FIELD_MIN);
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // Reset gains: zero, full-scale and saturating wheel and command patterns.
        send_item(make_item(0, 0, 0, 0, 0, 0, 0), 1'b1);
        send_item(make_item(hi, hi, hi, hi, hi, hi, hi), 1'b1);
        send_item(make_item(lo, lo, lo, lo, lo, lo, lo), 1'b1);
        send_item(make_item(lo, hi, hi, lo, hi, lo, lo), 1'b1);
        send_item(make_item(lo, hi, lo, hi, lo, hi, hi), 1'b1);
        send_item(make_item(1, -1, 2, -3, -1, 1, -1), 1'b1);
        settle();

        // Largest gains: everything but small inputs saturates.
        set_all_gains('1, '1, '1, '1, CFG_IDX_W'(IDX_TOP), '0);
        send_item(make_item(0, 0, 0, 0, 0, 0, 0), 1'b1);
        send_item(make_item(hi, hi, hi, hi, hi, hi, hi), 1'b1);
        send_item(make_item(lo, lo, lo, lo, lo, lo, lo), 1'b1);
        send_item(make_item(-1, 1, -1, 1, -1, 0, 1), 1'b1);
        send_item(make_item(3, -2, 0, 1, 2, -3, -2), 1'b1);
        settle();

        // Zero gains, written to an ignored index afterwards with all ones.
        set_all_gains('0, '0, '0, '0, CFG_IDX_W'(FIRST_UNUSED_IDX), '1);
        send_item(make_item(hi, lo, hi, lo, hi, lo, hi), 1'b1);
        send_item(make_item(lo, lo, hi, hi, lo, hi, lo), 1'b1);
        settle();

        // Smallest nonzero gains: truncation toward zero on both signs.
        set_all_gains(GAIN_W'(1), GAIN_W'(1), GAIN_W'(1), GAIN_W'(1),
                      CFG_IDX_W'(IDX_TOP), GAIN_RESET);
        send_item(make_item(-1, -4095, 4095, 4096, -4096, -1, 4097), 1'b1);
        send_item(make_item(lo, -4097, 4097, 1, -8191, 8191, -4096), 1'b1);
        send_item(make_item(hi, hi, hi, hi, lo, hi, lo), 1'b1);
        send_item(make_item(16'sh5555, 16'sh2aaa, -16'sh5555, 7, -7, 16'sh1000, 9), 1'b1);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            set_all_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                          CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, IDX_TOP)),
                          GAIN_W'($urandom_range(0, GAIN_TOP)));
            if (phase == HOLD_PHASE) begin
                long_hold = 1'b1;
            end
            if (phase == RANDOM_PHASES - 1) begin
                quiet = 1'b1;
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_item(random_item(), !quiet && phase != HOLD_PHASE);
            end
        end
        settle();

        $display("Checked %0d results for %0d items across %0d register writes.",
                 sb.results_checked, sb.items_noted, gain_writes);
        $display("The input side was held off for %0d cycles by result back-pressure.",
                 input_stalls);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("mecanum_body_wheel_kinematics test passed");
        end else begin
            $display("mecanum_body_wheel_kinematics test failed");
        end
        $finish;
    end

endmodule
